### rtl/ntw_pkg.sv
// ntw_pkg: shared types and constants for the number to word token core
// word codes, slot layout of a queued entry and reciprocal constants
// no dependencies
`default_nettype none

package ntw_pkg;

	localparam int VALUE_W       = 31;
	localparam int CODE_W        = 5;
	localparam int DIG_W         = 4;
	localparam int GRP_W         = 10;
	localparam int NUM_GRP       = 4;
	localparam int SLOTS_PER_GRP = 5;
	localparam int NUM_SLOTS     = NUM_GRP * SLOTS_PER_GRP + 1;

	// word slots inside one group, in reading order
	localparam int SLOT_DIGIT   = 0;
	localparam int SLOT_HUNDRED = 1;
	localparam int SLOT_TENS    = 2;
	localparam int SLOT_ONES    = 3;
	localparam int SLOT_SCALE   = 4;

	localparam logic [CODE_W-1:0] WORD_ZERO      = 5'd0;
	localparam logic [CODE_W-1:0] WORD_TEEN_BASE = 5'd10;
	localparam logic [CODE_W-1:0] WORD_TENS_BASE = 5'd18;
	localparam logic [CODE_W-1:0] WORD_HUNDRED   = 5'd28;
	localparam logic [CODE_W-1:0] WORD_THOUSAND  = 5'd29;
	localparam logic [CODE_W-1:0] WORD_MILLION   = 5'd30;
	localparam logic [CODE_W-1:0] WORD_BILLION   = 5'd31;

	// floor(x / 1000) as (x * recip) >> shift, exact over each operand width
	localparam logic [31:0] RECIP1       = 32'd2199023256;
	localparam int          RECIP1_SHIFT = 41;
	localparam logic [22:0] RECIP2       = 23'd4294968;
	localparam int          RECIP2_SHIFT = 32;
	localparam logic [12:0] RECIP3       = 13'd4195;
	localparam int          RECIP3_SHIFT = 22;

	// floor(g / 100) and floor(g / 10) for g below 1000
	localparam logic [6:0] RECIP_100       = 7'd41;
	localparam int         RECIP_100_SHIFT = 12;
	localparam logic [7:0] RECIP_10        = 8'd205;
	localparam int         RECIP_10_SHIFT  = 11;

	typedef struct packed {
		logic [DIG_W-1:0] hund;
		logic [DIG_W-1:0] tens;
		logic [DIG_W-1:0] ones;
	} grp_dig_t;

	// group 0 is the billion group, the top mask bit is the lone zero word
	typedef struct packed {
		logic [NUM_SLOTS-1:0]       mask;
		grp_dig_t [NUM_GRP-1:0]     grp;
	} entry_t;

endpackage

`default_nettype wire

### rtl/ntw_front.sv
// ntw_front: input pipeline that splits a value into four decimal groups
// and digits, and marks which word slots the reading uses
// depends on ntw_pkg
`default_nettype none

module ntw_front
	import ntw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               push,
	output entry_t             push_data,
	input  logic               q_full
);

	localparam int Q1_W = 22;
	localparam int Q2_W = 12;
	localparam int Q3_W = 2;
	localparam int D10_W = 7;

	logic adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic [VALUE_W-1:0] v_s1, v_s2;
	logic [Q1_W-1:0]    q1_s2, q1_s3;
	logic [Q2_W-1:0]    q2_s3, q2_s4;
	logic [Q3_W-1:0]    q3_s4;
	logic [GRP_W-1:0]   g3_s3, g3_s4;
	logic [GRP_W-1:0]   g2_s4;
	logic [GRP_W-1:0]   g_s5 [NUM_GRP];
	logic [GRP_W-1:0]   g_s6 [NUM_GRP];
	logic [DIG_W-1:0]   h_s6 [NUM_GRP];
	logic [D10_W-1:0]   d10_s6 [NUM_GRP];
	grp_dig_t           dig_s7 [NUM_GRP];

	logic [62:0]        prod1;
	logic [44:0]        prod2;
	logic [24:0]        prod3;
	logic [31:0]        rem3;
	logic [Q1_W-1:0]    rem2;
	logic [Q2_W-1:0]    rem1;
	logic [15:0]        prod100 [NUM_GRP];
	logic [17:0]        prod10 [NUM_GRP];
	logic [NUM_SLOTS-1:0] mask;

	assign adv      = !(vld_s7 && q_full);
	assign in_stall = !adv;

	assign prod1 = 63'(v_s1) * 63'(RECIP1);
	assign prod2 = 45'(q1_s2) * 45'(RECIP2);
	assign prod3 = 25'(q2_s3) * 25'(RECIP3);
	assign rem3  = 32'(v_s2) - 32'(q1_s2) * 32'd1000;
	assign rem2  = q1_s3 - Q1_W'(q2_s3) * Q1_W'(1000);
	assign rem1  = q2_s4 - Q2_W'(q3_s4) * Q2_W'(1000);

	always_comb begin
		for (int i = 0; i < NUM_GRP; i++) begin
			prod100[i] = 16'(g_s5[i]) * 16'(RECIP_100);
			prod10[i]  = 18'(g_s5[i]) * 18'(RECIP_10);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1  <= value;
			v_s2  <= v_s1;
			q1_s2 <= prod1[RECIP1_SHIFT+Q1_W-1:RECIP1_SHIFT];
			g3_s3 <= rem3[GRP_W-1:0];
			q2_s3 <= prod2[RECIP2_SHIFT+Q2_W-1:RECIP2_SHIFT];
			q1_s3 <= q1_s2;
			g2_s4 <= rem2[GRP_W-1:0];
			q3_s4 <= prod3[RECIP3_SHIFT+Q3_W-1:RECIP3_SHIFT];
			q2_s4 <= q2_s3;
			g3_s4 <= g3_s3;
			g_s5[0] <= GRP_W'(q3_s4);
			g_s5[1] <= rem1[GRP_W-1:0];
			g_s5[2] <= g2_s4;
			g_s5[3] <= g3_s4;
			for (int i = 0; i < NUM_GRP; i++) begin
				g_s6[i]        <= g_s5[i];
				h_s6[i]        <= prod100[i][RECIP_100_SHIFT+DIG_W-1:RECIP_100_SHIFT];
				d10_s6[i]      <= prod10[i][RECIP_10_SHIFT+D10_W-1:RECIP_10_SHIFT];
				dig_s7[i].hund <= h_s6[i];
				dig_s7[i].tens <= DIG_W'(d10_s6[i] - D10_W'(h_s6[i]) * D10_W'(10));
				dig_s7[i].ones <= DIG_W'(g_s6[i] - GRP_W'(d10_s6[i]) * GRP_W'(10));
			end
		end
	end

	always_comb begin
		mask = '0;
		for (int i = 0; i < NUM_GRP; i++) begin
			mask[i*SLOTS_PER_GRP+SLOT_DIGIT]   = |dig_s7[i].hund;
			mask[i*SLOTS_PER_GRP+SLOT_HUNDRED] = |dig_s7[i].hund;
			mask[i*SLOTS_PER_GRP+SLOT_TENS]    = |dig_s7[i].tens;
			mask[i*SLOTS_PER_GRP+SLOT_ONES]    = (|dig_s7[i].ones) &&
				(dig_s7[i].tens != DIG_W'(1));
			mask[i*SLOTS_PER_GRP+SLOT_SCALE]   = (i < NUM_GRP - 1) &&
				((|dig_s7[i].hund) || (|dig_s7[i].tens) || (|dig_s7[i].ones));
		end
		mask[NUM_SLOTS-1] = ~|mask[NUM_SLOTS-2:0];
	end

	always_comb begin
		push_data.mask = mask;
		for (int i = 0; i < NUM_GRP; i++) begin
			push_data.grp[i] = dig_s7[i];
		end
	end

	assign push = vld_s7 && !q_full;

endmodule

`default_nettype wire

### rtl/ntw_fifo.sv
// ntw_fifo: short queue of classified entries between front and back
// depends on ntw_pkg
`default_nettype none

module ntw_fifo
	import ntw_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/ntw_back.sv
// ntw_back: word sequencer that walks the slot mask of one entry, one word
// per cycle while the output is not stalled, into a registered output stage
// depends on ntw_pkg
`default_nettype none

module ntw_back
	import ntw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  entry_t            q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] word_code,
	output logic              last_word
);

	localparam logic [CODE_W-1:0] SCALE_CODE [NUM_GRP] =
		'{WORD_BILLION, WORD_MILLION, WORD_THOUSAND, WORD_ZERO};

	logic                   act_q;
	logic [NUM_SLOTS-1:0]   rem_q;
	grp_dig_t [NUM_GRP-1:0] grp_q;
	logic                   ov_q;
	logic [CODE_W-1:0]      code_q;
	logic                   last_q;

	logic [CODE_W-1:0]    code [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] oh;
	logic [CODE_W-1:0]    sel_code;
	logic                 sel_last;
	logic                 out_ok;
	logic                 emit;
	logic                 load;

	always_comb begin
		for (int i = 0; i < NUM_GRP; i++) begin
			code[i*SLOTS_PER_GRP+SLOT_DIGIT]   = CODE_W'(grp_q[i].hund);
			code[i*SLOTS_PER_GRP+SLOT_HUNDRED] = WORD_HUNDRED;
			code[i*SLOTS_PER_GRP+SLOT_TENS]    = (grp_q[i].tens == DIG_W'(1)) ?
				WORD_TEEN_BASE + CODE_W'(grp_q[i].ones) :
				WORD_TENS_BASE + CODE_W'(grp_q[i].tens);
			code[i*SLOTS_PER_GRP+SLOT_ONES]    = CODE_W'(grp_q[i].ones);
			code[i*SLOTS_PER_GRP+SLOT_SCALE]   = SCALE_CODE[i];
		end
		code[NUM_SLOTS-1] = WORD_ZERO;
	end

	// lowest remaining slot is the next word
	assign oh = rem_q & (~rem_q + 1'b1);

	always_comb begin
		sel_code = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			sel_code = sel_code | (oh[i] ? code[i] : '0);
		end
	end

	assign sel_last = ~|(rem_q & ~oh);
	assign out_ok   = !ov_q || !out_stall;
	assign emit     = act_q && out_ok;
	assign load     = q_nonempty && (!act_q || (emit && sel_last));
	assign pop      = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				act_q <= 1'b1;
			end else if (emit && sel_last) begin
				act_q <= 1'b0;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= q_data.mask;
			grp_q <= q_data.grp;
		end else if (emit) begin
			rem_q <= rem_q & ~oh;
		end
		if (emit) begin
			code_q <= sel_code;
			last_q <= sel_last;
		end
	end

	assign out_valid = ov_q;
	assign word_code = code_q;
	assign last_word = last_q;

endmodule

`default_nettype wire

### rtl/number_to_word_tokens_core.sv
// number_to_word_tokens_core: top level of the integer to English word code reader
// instantiates ntw_front, ntw_fifo and ntw_back; depends on ntw_pkg
`default_nettype none

// Reads a 31-bit unsigned value as a run of English word codes, one code per
// transfer on the output channel, with last_word set on the final word. A value
// gives 1 to 16 words; the back end sequencer emits one word per cycle while
// the output is not stalled and sets the rate, so back-to-back values stream
// with no gap between runs. The front end is a 7-stage pipeline (decimal group
// split and digit extraction) that takes a new value every cycle until the
// QUEUE_DEPTH entry queue in front of the sequencer is full. A value reaches
// the output register through the front end, the queue and the sequencer.

module number_to_word_tokens_core
	import ntw_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [CODE_W-1:0]  word_code,
	output logic               last_word
);

	logic   push;
	entry_t push_data;
	logic   q_full;
	logic   pop;
	entry_t pop_data;
	logic   q_nonempty;

	ntw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ntw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (q_nonempty)
	);

	ntw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (pop_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word_code  (word_code),
		.last_word  (last_word)
	);

endmodule

`default_nettype wire

### rtl/ntw_chk.sv
// ntw_chk: port-level checker for number_to_word_tokens_core, bound to the top
// depends on ntw_pkg
`default_nettype none

module ntw_chk
	import ntw_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [CODE_W-1:0]  word_code,
	input logic               last_word
);

	// pipeline stages, queue, active entry and output register
	localparam int MAX_OPEN = QUEUE_DEPTH + 9;
	localparam int OPEN_W   = $clog2(MAX_OPEN + 2);

	logic              in_xfer;
	logic              out_xfer;
	logic [OPEN_W-1:0] open_q;
	logic              first_q;
	logic [CODE_W-1:0] prev_code_q;

	assign in_xfer    = in_valid && !in_stall;
	assign out_xfer   = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= '0;
			first_q     <= 1'b1;
			prev_code_q <= WORD_ZERO;
		end else begin
			open_q <= open_q + OPEN_W'(in_xfer) - OPEN_W'(out_xfer && last_word);
			if (out_xfer) begin
				first_q     <= last_word;
				prev_code_q <= word_code;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_code) && $stable(last_word))
		else $error("output transfer changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> open_q != '0)
		else $error("word transfer with no value outstanding");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> open_q < OPEN_W'(MAX_OPEN))
		else $error("more values in flight than the block can hold");

	a_zero_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && word_code == WORD_ZERO |-> last_word && first_q)
		else $error("zero word not alone in its run");

	a_hundred_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && word_code == WORD_HUNDRED |->
			!first_q && prev_code_q != WORD_ZERO && prev_code_q < WORD_TEEN_BASE)
		else $error("hundred word not preceded by a digit word");

endmodule

bind number_to_word_tokens_core ntw_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ntw_chk (.*);

`default_nettype wire

### sim/number_to_word_tokens_core_tb.sv
// number_to_word_tokens_core_tb: self-checking bench for the integer to English word code reader
// directed table then bursty random values, every word checked against a typed table entry or an in-bench reading
// depends on ntw_pkg and number_to_word_tokens_core
`default_nettype none

module number_to_word_tokens_core_tb;
	import ntw_pkg::*;

	localparam int RANDOM_VALUES = 350;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int DIR_N         = 25;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} word_t;

	// rows with a typed count of zero are read through the predictor
	localparam logic [VALUE_W-1:0] DIR_VALUE [DIR_N] = '{
		31'd0, 31'd1, 31'd19, 31'd20, 31'd90, 31'd100, 31'd1000, 31'd1000000,
		31'd1000000000, 31'd2000000000, 31'd10, 31'd13, 31'd21, 31'd99, 31'd101,
		31'd110, 31'd999, 31'd1001, 31'd1000001, 31'd1000000001, 31'd2147483647,
		31'd1777777777, 31'd1010010010, 31'd2000000999, 31'd300000
	};
	localparam int DIR_TYPED [DIR_N] = '{
		1, 1, 1, 1, 1, 2, 2, 2, 2, 2, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0
	};
	localparam logic [CODE_W-1:0] DIR_CODE0 [DIR_N] = '{
		WORD_ZERO, 5'd1, 5'd19, WORD_TENS_BASE + 5'd2, WORD_TENS_BASE + 5'd9,
		5'd1, 5'd1, 5'd1, 5'd1, 5'd2, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO,
		WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO,
		WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO
	};
	localparam logic [CODE_W-1:0] DIR_CODE1 [DIR_N] = '{
		WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_HUNDRED,
		WORD_THOUSAND, WORD_MILLION, WORD_BILLION, WORD_BILLION, WORD_ZERO,
		WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO,
		WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO, WORD_ZERO,
		WORD_ZERO, WORD_ZERO
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [VALUE_W-1:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CODE_W-1:0]  word_code;
	logic               last_word;

	word_t       pending_words [$];
	int          errors = 0;
	int          values_sent = 0;
	int          words_checked = 0;
	int          runs_checked = 0;
	int          cycle_count = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	int          stall_step = 0;
	word_t       want;

	number_to_word_tokens_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.word_code (word_code),
		.last_word (last_word)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// English reading of one value, appended to the pending words
	function automatic void queue_reading(input logic [VALUE_W-1:0] v);
		int unsigned n;
		int unsigned grp [4];
		int unsigned g;
		int unsigned rest;
		logic [CODE_W-1:0] scale [3];
		logic [CODE_W-1:0] codes [$];
		word_t w;
		scale[0] = WORD_BILLION;
		scale[1] = WORD_MILLION;
		scale[2] = WORD_THOUSAND;
		n = v;
		if (n == 0) begin
			codes.push_back(WORD_ZERO);
		end else begin
			grp[3] = n % 1000;
			n = n / 1000;
			grp[2] = n % 1000;
			n = n / 1000;
			grp[1] = n % 1000;
			grp[0] = n / 1000;
			for (int i = 0; i < 4; i++) begin
				g = grp[i];
				if (g == 0)
					continue;
				if (g >= 100) begin
					codes.push_back(CODE_W'(g / 100));
					codes.push_back(WORD_HUNDRED);
				end
				rest = g % 100;
				if (rest > 0 && rest < 20) begin
					codes.push_back(CODE_W'(rest));
				end else begin
					if (rest / 10 >= 2)
						codes.push_back(WORD_TENS_BASE + CODE_W'(rest / 10));
					if (rest % 10 > 0)
						codes.push_back(CODE_W'(rest % 10));
				end
				if (i < 3)
					codes.push_back(scale[i]);
			end
		end
		foreach (codes[k]) begin
			w.code = codes[k];
			w.last = (k == codes.size() - 1);
			pending_words.push_back(w);
		end
	endfunction

	// random value: full range, small, or built from groups with zeros, teens, round hundreds and 999
	function automatic logic [VALUE_W-1:0] pick_value();
		longint unsigned acc;
		int unsigned g;
		acc = 0;
		case ($urandom_range(0, 3))
			0: return VALUE_W'($urandom());
			1: return VALUE_W'($urandom_range(0, 999));
			default: begin
				for (int i = 0; i < 4; i++) begin
					case ($urandom_range(0, 5)) inside
						[0:1]: g = 0;
						2: g = $urandom_range(10, 20);
						3: g = $urandom_range(1, 9) * 100;
						4: g = 999;
						default: g = $urandom_range(1, 999);
					endcase
					if (i == 0)
						g = g % 3;
					acc = acc * 1000 + g;
				end
				if (acc > VALUE_MAX)
					acc = acc - 1000000000;
				return VALUE_W'(acc);
			end
		endcase
	endfunction

	task automatic send_value(input logic [VALUE_W-1:0] v);
		value    <= v;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		values_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// output side: check each transfer, then choose the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: word_code %0d last_word %0b", word_code, last_word);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (word_code !== want.code) begin
					$error("word_code: expected %0d, actual %0d", want.code, word_code);
					errors++;
				end
				if (last_word !== want.last) begin
					$error("last_word: expected %0b, actual %0b", want.last, last_word);
					errors++;
				end
				words_checked++;
				if (want.last)
					runs_checked++;
			end
		end
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
			stall_step <= 0;
		end else begin
			stall_left <= stall_left - 1;
			stall_step <= stall_step + 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= stall_step[0];
			default: out_stall <= (stall_step % 12) < 7;
		endcase
	end

	initial begin
		int burst;
		int next_drain;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			send_value(DIR_VALUE[r]);
			if (DIR_TYPED[r] == 0) begin
				queue_reading(DIR_VALUE[r]);
			end else if (DIR_TYPED[r] == 1) begin
				pending_words.push_back('{code: DIR_CODE0[r], last: 1'b1});
			end else begin
				pending_words.push_back('{code: DIR_CODE0[r], last: 1'b0});
				pending_words.push_back('{code: DIR_CODE1[r], last: 1'b1});
			end
		end
		wait_drained();

		next_drain = values_sent + 120;
		while (values_sent < DIR_N + RANDOM_VALUES) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst; k++) begin
				send_value(pick_value());
				queue_reading(value);
			end
			if (values_sent >= next_drain) begin
				wait_drained();
				next_drain = values_sent + 120;
			end else if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		wait_drained();
		repeat (40) @(posedge clk);

		$display("read out %0d values, %0d words over %0d runs checked",
			values_sent, words_checked, runs_checked);
		$display("stalls and sender gaps varied throughout, with drained pauses");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
